### src/ccws_pkg.sv
// ccws_pkg: polynomials and byte update functions for the crc-7 / crc-16 word stream
package ccws_pkg;

    localparam int unsigned WordWidth  = 16;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned Crc7Width  = 7;
    localparam int unsigned Crc16Width = 16;

    localparam logic [Crc7Width-1:0]  Crc7Poly  = 7'h09;
    localparam logic [Crc16Width-1:0] Crc16Poly = 16'h1021;

    typedef logic [WordWidth-1:0]  word_t;
    typedef logic [ByteWidth-1:0]  byte_t;
    typedef logic [Crc7Width-1:0]  crc7_t;
    typedef logic [Crc16Width-1:0] crc16_t;

    // eight serial lfsr steps for crc-7, byte fed lsb first
    function automatic crc7_t crc7_byte(input crc7_t crc_in, input byte_t data);
        crc7_t crc;
        logic  fb;
        crc = crc_in;
        for (int i = 0; i < ByteWidth; i++)
        begin
            fb  = data[i] ^ crc[Crc7Width-1];
            crc = {crc[Crc7Width-2:0], 1'b0} ^ (fb ? Crc7Poly : '0);
        end
        return crc;
    endfunction

    // eight serial lfsr steps for crc-16, byte fed lsb first
    function automatic crc16_t crc16_byte(input crc16_t crc_in, input byte_t data);
        crc16_t crc;
        logic   fb;
        crc = crc_in;
        for (int i = 0; i < ByteWidth; i++)
        begin
            fb  = data[i] ^ crc[Crc16Width-1];
            crc = {crc[Crc16Width-2:0], 1'b0} ^ (fb ? Crc16Poly : '0);
        end
        return crc;
    endfunction

endpackage

### src/crc7_crc16_word_stream.sv
// crc7_crc16_word_stream: crc-7 and crc-16 over a stream of 16-bit words
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+--------------------------------
//  in      | in        | in_valid / in_stall | msg_word[15:0], last_word
//  out     | out       | out_valid/out_stall | crc_seven[6:0], crc_sixteen[15:0]
//
// one word per cycle unless in_stall: each word passes the input register, and the
// sixteen unrolled lfsr steps run between it and the crc state / result register.
// a last word yields one result transaction via the input, then the result register.
// rst_n clears valids and both crc registers at once, no clearing pass.
// a stalled result blocks only a following last word; other words keep flowing.
module crc7_crc16_word_stream
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ccws_pkg::WordWidth-1:0] msg_word,
    input  logic                           last_word,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ccws_pkg::Crc7Width-1:0] crc_seven,
    output logic [ccws_pkg::Crc16Width-1:0] crc_sixteen
);

    // input register
    logic              in_valid_reg;
    ccws_pkg::word_t   word_reg;
    logic              last_reg;

    // running crc state
    ccws_pkg::crc7_t   crc7_reg;
    ccws_pkg::crc16_t  crc16_reg;

    // result register
    logic              out_valid_reg;
    ccws_pkg::crc7_t   res7_reg;
    ccws_pkg::crc16_t  res16_reg;

    ccws_pkg::crc7_t   crc7_next;
    ccws_pkg::crc16_t  crc16_next;
    logic              out_free;
    logic              advance;
    logic              emit;

    // crc update over high byte then low byte
    always_comb
    begin
        crc7_next  = ccws_pkg::crc7_byte(
                         ccws_pkg::crc7_byte(crc7_reg, word_reg[15:8]), word_reg[7:0]);
        crc16_next = ccws_pkg::crc16_byte(
                         ccws_pkg::crc16_byte(crc16_reg, word_reg[15:8]), word_reg[7:0]);
    end

    // stage control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = in_valid_reg && (!last_reg || out_free);
    assign emit     = advance && last_reg;
    assign in_stall = in_valid_reg && !advance;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            word_reg <= msg_word;
            last_reg <= last_word;
        end
    end

    // crc state, cleared after the last word of a message
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc7_reg  <= '0;
            crc16_reg <= '0;
        end
        else if (advance)
        begin
            if (last_reg)
            begin
                crc7_reg  <= '0;
                crc16_reg <= '0;
            end
            else
            begin
                crc7_reg  <= crc7_next;
                crc16_reg <= crc16_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res7_reg  <= crc7_next;
            res16_reg <= crc16_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign crc_seven   = res7_reg;
    assign crc_sixteen = res16_reg;

endmodule
